### hw/rtl/ccst_pkg.sv
// Shared types and constants for the coulomb counter state-of-charge tracker.
// Used by the config register file, controller, datapath and top level.
package ccst_pkg;

	localparam int unsigned SAMPLE_PERIOD_MS = 1000;
	localparam int unsigned VOLT_HYST_MV     = 500;

	localparam logic [30:0] FULL_Q    = 31'd1677721600;
	localparam int unsigned PCT_SHIFT = 24;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CHARGE_GAIN     = 3'd0,
		REG_DEADBAND_MA     = 3'd1,
		REG_TAIL_CURRENT_MA = 3'd2,
		REG_FULL_VOLTAGE_MV = 3'd3,
		REG_FULL_HOLD_MS    = 3'd4,
		REG_SOC_LOW_PCT     = 3'd5,
		REG_SOC_RECOVER_PCT = 3'd6,
		REG_CRITICAL_MV     = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [31:0] charge_gain;
		logic [14:0] deadband_ma;
		logic [14:0] tail_current_ma;
		logic [15:0] full_voltage_mv;
		logic [31:0] full_hold_ms;
		logic [6:0]  soc_low_pct;
		logic [6:0]  soc_recover_pct;
		logic [15:0] critical_mv;
	} cfg_t;

	localparam logic [31:0] RST_CHARGE_GAIN     = 32'd20000000;
	localparam logic [14:0] RST_DEADBAND_MA     = 15'd50;
	localparam logic [14:0] RST_TAIL_CURRENT_MA = 15'd2000;
	localparam logic [15:0] RST_FULL_VOLTAGE_MV = 16'd14400;
	localparam logic [31:0] RST_FULL_HOLD_MS    = 32'd60000;
	localparam logic [6:0]  RST_SOC_LOW_PCT     = 7'd20;
	localparam logic [6:0]  RST_SOC_RECOVER_PCT = 7'd30;
	localparam logic [15:0] RST_CRITICAL_MV     = 16'd11000;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MUL,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic check;
		logic mul;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic skip;
	} status_t;

endpackage

### hw/rtl/ccst_cfg.sv
// Configuration register file for the state-of-charge tracker.
// Depends on ccst_pkg for the register index codes and the cfg_t bundle.
module ccst_cfg
	import ccst_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.charge_gain     <= RST_CHARGE_GAIN;
			cfg_q.deadband_ma     <= RST_DEADBAND_MA;
			cfg_q.tail_current_ma <= RST_TAIL_CURRENT_MA;
			cfg_q.full_voltage_mv <= RST_FULL_VOLTAGE_MV;
			cfg_q.full_hold_ms    <= RST_FULL_HOLD_MS;
			cfg_q.soc_low_pct     <= RST_SOC_LOW_PCT;
			cfg_q.soc_recover_pct <= RST_SOC_RECOVER_PCT;
			cfg_q.critical_mv     <= RST_CRITICAL_MV;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				REG_CHARGE_GAIN:     cfg_q.charge_gain     <= cfg_data;
				REG_DEADBAND_MA:     cfg_q.deadband_ma     <= cfg_data[14:0];
				REG_TAIL_CURRENT_MA: cfg_q.tail_current_ma <= cfg_data[14:0];
				REG_FULL_VOLTAGE_MV: cfg_q.full_voltage_mv <= cfg_data[15:0];
				REG_FULL_HOLD_MS:    cfg_q.full_hold_ms    <= cfg_data;
				REG_SOC_LOW_PCT:     cfg_q.soc_low_pct     <= cfg_data[6:0];
				REG_SOC_RECOVER_PCT: cfg_q.soc_recover_pct <= cfg_data[6:0];
				REG_CRITICAL_MV:     cfg_q.critical_mv     <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### hw/rtl/ccst_ctrl.sv
// Sequencing controller for the state-of-charge tracker.
// Depends on ccst_pkg; drives the datapath through cmd_t and owns the handshakes.
module ccst_ctrl
	import ccst_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	output logic    out_valid,
	input  logic    out_stall,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q, state_d;
	logic   out_valid_q, out_valid_d;
	logic   out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		out_free = !out_valid_q || !out_stall;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (status.skip) begin
					state_d = ST_IDLE;
				end else begin
					cmd.check = 1'b1;
					state_d   = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		if (cmd.commit)
			out_valid_d = 1'b1;
		else if (out_valid_q && !out_stall)
			out_valid_d = 1'b0;
		else
			out_valid_d = out_valid_q;
	end

	assign out_valid = out_valid_q;

endmodule

### hw/rtl/ccst_dp.sv
// Datapath for the state-of-charge tracker: sample gate, two-step charge
// multiply, charge clamp, full-charge hold timer and safety hysteresis. Depends on ccst_pkg.
module ccst_dp
	import ccst_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  cmd_t               cmd,
	output status_t            status,
	input  logic [31:0]        now_ms,
	input  logic               sensor_ok,
	input  logic [15:0]        bus_mv,
	input  logic signed [15:0] raw_current_ma,
	output logic [30:0]        soc_q,
	output logic [15:0]        voltage_out_mv,
	output logic signed [15:0] current_out_ma,
	output logic               reading_valid,
	output logic               safe,
	output logic               safety_changed,
	output logic               full_reset_done
);

	logic [31:0]        now_q;
	logic               ok_q;
	logic [15:0]        mv_q;
	logic signed [15:0] raw_q;

	logic [31:0]        last_time_q;
	logic [30:0]        charge_q;
	logic [15:0]        held_mv_q;
	logic signed [15:0] held_cur_q;
	logic               armed_q;
	logic [31:0]        hold_start_q;
	logic               charge_unsafe_q;
	logic               volt_unsafe_q;

	logic signed [15:0] cur_q;
	logic [14:0]        mag_q;
	logic [30:0]        prod1_q;
	logic [62:0]        prod2_q;
	logic               no_int_q;
	logic               full_cond_q;
	logic               hold_due_q;
	logic               v_low_q;
	logic               v_high_q;

	logic [30:0]        soc_out_q;
	logic [15:0]        mv_out_q;
	logic signed [15:0] cur_out_q;
	logic               valid_out_q;
	logic               safe_out_q;
	logic               changed_out_q;
	logic               full_out_q;

	logic [31:0]        elapsed;
	logic [15:0]        dt;
	logic signed [15:0] cur;
	logic [14:0]        mag;
	logic [30:0]        step;
	logic [31:0]        sum;
	logic [31:0]        diff;
	logic [30:0]        lvl;
	logic [30:0]        lvl2;
	logic               arm_set;
	logic               arm_clr;
	logic               forced;
	logic               cu_d;
	logic               vu_d;
	logic               was_safe;
	logic [16:0]        v_recover;

	always_comb begin
		elapsed     = now_q - last_time_q;
		status.skip = elapsed < 32'(SAMPLE_PERIOD_MS);
		dt          = (elapsed[31:16] != 16'd0) ? 16'hFFFF : elapsed[15:0];
		cur         = (raw_q == 16'sh8000) ? 16'sh7FFF : -raw_q;
		mag         = cur[15] ? 15'(-cur) : cur[14:0];
		v_recover   = {1'b0, cfg.critical_mv} + 17'(VOLT_HYST_MV);

		step = prod2_q[62:32];
		sum  = {1'b0, charge_q} + {1'b0, step};
		diff = {1'b0, charge_q} - {1'b0, step};
		if (no_int_q)
			lvl = charge_q;
		else if (cur_q[15])
			lvl = diff[31] ? 31'd0 : diff[30:0];
		else
			lvl = (sum > {1'b0, FULL_Q}) ? FULL_Q : sum[30:0];

		lvl2    = lvl;
		arm_set = 1'b0;
		arm_clr = 1'b0;
		forced  = 1'b0;
		if (lvl < FULL_Q) begin
			if (full_cond_q) begin
				if (!armed_q) begin
					arm_set = 1'b1;
				end else if (hold_due_q) begin
					lvl2    = FULL_Q;
					arm_clr = 1'b1;
					forced  = 1'b1;
				end
			end else begin
				arm_clr = 1'b1;
			end
		end

		if (lvl2 <= {cfg.soc_low_pct, 24'd0})
			cu_d = 1'b1;
		else if (lvl2 >= {cfg.soc_recover_pct, 24'd0})
			cu_d = 1'b0;
		else
			cu_d = charge_unsafe_q;
		if (v_low_q)
			vu_d = 1'b1;
		else if (v_high_q)
			vu_d = 1'b0;
		else
			vu_d = volt_unsafe_q;
		was_safe = !charge_unsafe_q && !volt_unsafe_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			now_q <= now_ms;
			ok_q  <= sensor_ok;
			mv_q  <= bus_mv;
			raw_q <= raw_current_ma;
		end
		if (cmd.check) begin
			cur_q   <= cur;
			mag_q   <= mag;
			prod1_q <= 31'(mag) * 31'(dt);
		end
		if (cmd.mul) begin
			prod2_q     <= 63'(prod1_q) * 63'(cfg.charge_gain);
			no_int_q    <= mag_q <= cfg.deadband_ma;
			full_cond_q <= (mag_q <= cfg.tail_current_ma) && (mv_q >= cfg.full_voltage_mv);
			hold_due_q  <= (now_q - hold_start_q) >= cfg.full_hold_ms;
			v_low_q     <= mv_q <= cfg.critical_mv;
			v_high_q    <= {1'b0, mv_q} >= v_recover;
		end
		if (cmd.commit) begin
			if (ok_q) begin
				soc_out_q     <= lvl2;
				mv_out_q      <= mv_q;
				cur_out_q     <= cur_q;
				valid_out_q   <= 1'b1;
				safe_out_q    <= !cu_d && !vu_d;
				changed_out_q <= (!cu_d && !vu_d) != was_safe;
				full_out_q    <= forced;
			end else begin
				soc_out_q     <= charge_q;
				mv_out_q      <= held_mv_q;
				cur_out_q     <= held_cur_q;
				valid_out_q   <= 1'b0;
				safe_out_q    <= was_safe;
				changed_out_q <= 1'b0;
				full_out_q    <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_time_q     <= '0;
			charge_q        <= FULL_Q;
			held_mv_q       <= '0;
			held_cur_q      <= '0;
			armed_q         <= 1'b0;
			hold_start_q    <= '0;
			charge_unsafe_q <= 1'b0;
			volt_unsafe_q   <= 1'b0;
		end else begin
			if (cmd.check)
				last_time_q <= now_q;
			if (cmd.commit && ok_q) begin
				charge_q        <= lvl2;
				held_mv_q       <= mv_q;
				held_cur_q      <= cur_q;
				charge_unsafe_q <= cu_d;
				volt_unsafe_q   <= vu_d;
				if (arm_set) begin
					armed_q      <= 1'b1;
					hold_start_q <= now_q;
				end else if (arm_clr) begin
					armed_q <= 1'b0;
				end
			end
		end
	end

	assign soc_q           = soc_out_q;
	assign voltage_out_mv  = mv_out_q;
	assign current_out_ma  = cur_out_q;
	assign reading_valid   = valid_out_q;
	assign safe            = safe_out_q;
	assign safety_changed  = changed_out_q;
	assign full_reset_done = full_out_q;

endmodule

### hw/rtl/coulomb_counter_soc_tracker_top.sv
// Top level of the coulomb counter state-of-charge tracker.
// Depends on ccst_pkg, ccst_cfg, ccst_ctrl and ccst_dp.

// Each request goes through these steps from acceptance to a loaded result: capture,
// sample-period check with the current-by-time multiply, the multiply by
// charge_gain, and the charge update. A request that arrives less than one
// sample period after the last counted one is dropped at the sample-period check and
// gives no result. One request is in work at a time; the next is taken while
// a finished result still waits on out_stall, and the update stage holds
// until the output register is free. Configuration writes take effect on
// the next clock edge.
module coulomb_counter_soc_tracker_top
	import ccst_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [31:0]           now_ms,
	input  logic                  sensor_ok,
	input  logic [15:0]           bus_mv,
	input  logic signed [15:0]    raw_current_ma,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [30:0]           soc_q,
	output logic [15:0]           voltage_out_mv,
	output logic signed [15:0]    current_out_ma,
	output logic                  reading_valid,
	output logic                  safe,
	output logic                  safety_changed,
	output logic                  full_reset_done
);

	cfg_t    cfg;
	cmd_t    cmd;
	status_t status;

	ccst_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ccst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	ccst_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.cmd             (cmd),
		.status          (status),
		.now_ms          (now_ms),
		.sensor_ok       (sensor_ok),
		.bus_mv          (bus_mv),
		.raw_current_ma  (raw_current_ma),
		.soc_q           (soc_q),
		.voltage_out_mv  (voltage_out_mv),
		.current_out_ma  (current_out_ma),
		.reading_valid   (reading_valid),
		.safe            (safe),
		.safety_changed  (safety_changed),
		.full_reset_done (full_reset_done)
	);

endmodule

### tb/sv/soc_reading_checker.sv
// Checker for the coulomb counter state-of-charge tracker: watches the config port and
// both request channels, predicts each reading and compares it against the block's output.
// Depends on ccst_pkg.
module soc_reading_checker
	import ccst_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic [31:0]           now_ms,
	input  logic                  sensor_ok,
	input  logic [15:0]           bus_mv,
	input  logic signed [15:0]    raw_current_ma,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic [30:0]           soc_q,
	input  logic [15:0]           voltage_out_mv,
	input  logic signed [15:0]    current_out_ma,
	input  logic                  reading_valid,
	input  logic                  safe,
	input  logic                  safety_changed,
	input  logic                  full_reset_done,
	output int                    fail_count,
	output int                    pending
);

	typedef struct packed {
		logic [30:0] soc;
		logic [15:0] volts;
		logic [15:0] amps;
		logic        valid;
		logic        safe;
		logic        changed;
		logic        full;
	} reading_t;

	cfg_t        cfg;
	logic [31:0] last_stamp;
	logic [31:0] hold_stamp;
	logic [30:0] charge_q;
	logic [15:0] held_mv;
	logic [15:0] held_ma;
	logic        hold_armed;
	logic        soc_low_flag;
	logic        volt_low_flag;
	reading_t    readings[$];
	int          errs;

	function automatic bit predict_sample(input logic [31:0] stamp, input logic ok,
			input logic [15:0] mv, input logic [15:0] raw, output reading_t r);
		logic [31:0] elapsed;
		logic [31:0] held_for;
		logic [15:0] dt;
		logic [63:0] step;
		longint      level;
		int          amps;
		int          mag;
		logic        was_safe;
		logic        forced;
		elapsed = stamp - last_stamp;
		if (elapsed < SAMPLE_PERIOD_MS)
			return 1'b0;
		dt = (elapsed > 32'd65535) ? 16'hFFFF : elapsed[15:0];
		last_stamp = stamp;
		forced = 1'b0;
		was_safe = !soc_low_flag && !volt_low_flag;
		if (ok) begin
			amps = -int'($signed(raw));
			if (amps > 32767)
				amps = 32767;
			held_mv = mv;
			held_ma = 16'(amps);
			mag = (amps < 0) ? -amps : amps;
			level = longint'(charge_q);
			if (mag > int'(cfg.deadband_ma)) begin
				step = (64'(mag) * 64'(dt) * 64'(cfg.charge_gain)) >> 32;
				if (amps < 0)
					level = level - longint'(step);
				else
					level = level + longint'(step);
			end
			if (level > longint'(FULL_Q))
				level = longint'(FULL_Q);
			if (level < 0)
				level = 0;
			charge_q = 31'(level);
			if (charge_q < FULL_Q) begin
				if (mag <= int'(cfg.tail_current_ma) && mv >= cfg.full_voltage_mv) begin
					held_for = stamp - hold_stamp;
					if (!hold_armed) begin
						hold_armed = 1'b1;
						hold_stamp = stamp;
					end else if (held_for >= cfg.full_hold_ms) begin
						charge_q = FULL_Q;
						hold_armed = 1'b0;
						forced = 1'b1;
					end
				end else begin
					hold_armed = 1'b0;
				end
			end
			if (64'(charge_q) <= (64'(cfg.soc_low_pct) << PCT_SHIFT))
				soc_low_flag = 1'b1;
			else if (64'(charge_q) >= (64'(cfg.soc_recover_pct) << PCT_SHIFT))
				soc_low_flag = 1'b0;
			if (mv <= cfg.critical_mv)
				volt_low_flag = 1'b1;
			else if (32'(mv) >= 32'(cfg.critical_mv) + VOLT_HYST_MV)
				volt_low_flag = 1'b0;
		end
		r.soc = charge_q;
		r.volts = held_mv;
		r.amps = held_ma;
		r.valid = ok;
		r.safe = !soc_low_flag && !volt_low_flag;
		r.changed = ok && (r.safe != was_safe);
		r.full = forced;
		return 1'b1;
	endfunction

	task automatic check_field(input string what, input longint want, input longint got);
		if (want != got) begin
			errs++;
			$display("%0t %s mismatch: expected %0d, actual %0d", $time, what, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		reading_t r;
		reading_t want;
		if (!arst_n) begin
			cfg.charge_gain = RST_CHARGE_GAIN;
			cfg.deadband_ma = RST_DEADBAND_MA;
			cfg.tail_current_ma = RST_TAIL_CURRENT_MA;
			cfg.full_voltage_mv = RST_FULL_VOLTAGE_MV;
			cfg.full_hold_ms = RST_FULL_HOLD_MS;
			cfg.soc_low_pct = RST_SOC_LOW_PCT;
			cfg.soc_recover_pct = RST_SOC_RECOVER_PCT;
			cfg.critical_mv = RST_CRITICAL_MV;
			last_stamp = '0;
			hold_stamp = '0;
			charge_q = FULL_Q;
			held_mv = '0;
			held_ma = '0;
			hold_armed = 1'b0;
			soc_low_flag = 1'b0;
			volt_low_flag = 1'b0;
			readings.delete();
		end else begin
			if (in_valid && !in_stall &&
					predict_sample(now_ms, sensor_ok, bus_mv, raw_current_ma, r))
				readings.push_back(r);
			if (out_valid && !out_stall) begin
				if (readings.size() == 0) begin
					errs++;
					$display("%0t reading mismatch: expected none, actual soc_q %0d",
						$time, soc_q);
				end else begin
					want = readings.pop_front();
					check_field("soc_q", want.soc, soc_q);
					check_field("voltage_out_mv", want.volts, voltage_out_mv);
					check_field("current_out_ma", longint'($signed(want.amps)),
						longint'(current_out_ma));
					check_field("reading_valid", want.valid, reading_valid);
					check_field("safe", want.safe, safe);
					check_field("safety_changed", want.changed, safety_changed);
					check_field("full_reset_done", want.full, full_reset_done);
				end
			end
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					REG_CHARGE_GAIN:     cfg.charge_gain = cfg_data;
					REG_DEADBAND_MA:     cfg.deadband_ma = cfg_data[14:0];
					REG_TAIL_CURRENT_MA: cfg.tail_current_ma = cfg_data[14:0];
					REG_FULL_VOLTAGE_MV: cfg.full_voltage_mv = cfg_data[15:0];
					REG_FULL_HOLD_MS:    cfg.full_hold_ms = cfg_data;
					REG_SOC_LOW_PCT:     cfg.soc_low_pct = cfg_data[6:0];
					REG_SOC_RECOVER_PCT: cfg.soc_recover_pct = cfg_data[6:0];
					REG_CRITICAL_MV:     cfg.critical_mv = cfg_data[15:0];
					default: ;
				endcase
			end
		end
		fail_count <= errs;
		pending <= readings.size();
	end

endmodule

### tb/sv/tb_coulomb_counter_soc_tracker_top.sv
// Testbench top for the coulomb counter state-of-charge tracker: drives samples, config
// phases and output stalls, and gives the verdict from the failure count of the checker.
// Depends on ccst_pkg, coulomb_counter_soc_tracker_top and soc_reading_checker.
module tb_coulomb_counter_soc_tracker_top
	import ccst_pkg::*;
;

	localparam int CYCLE_LIMIT = 200000;

	typedef enum int {DRAIN, CHARGE, FLOAT, NOISE} load_mode_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [31:0]           now_ms = '0;
	logic                  sensor_ok = 1'b0;
	logic [15:0]           bus_mv = '0;
	logic signed [15:0]    raw_current_ma = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [30:0]           soc_q;
	logic [15:0]           voltage_out_mv;
	logic signed [15:0]    current_out_ma;
	logic                  reading_valid;
	logic                  safe;
	logic                  safety_changed;
	logic                  full_reset_done;
	int                    fail_count;
	int                    pending;
	int                    cycles = 0;
	bit                    calm = 1'b0;
	logic [31:0]           clock_ms = '0;
	cfg_t                  shadow;

	coulomb_counter_soc_tracker_top i_dut (.*);

	soc_reading_checker i_checker (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		forever begin
			repeat ($urandom_range(1, 24)) @(posedge clk);
			if (!calm && $urandom_range(0, 2) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 17)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_sample(input logic [31:0] stamp, input logic ok, input logic [15:0] mv,
			input logic [15:0] amps);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_valid <= 1'b1;
		now_ms <= stamp;
		sensor_ok <= ok;
		bus_mv <= mv;
		raw_current_ma <= amps;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// drop the request line and hold until every reading is back and the block is quiet
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic load_settings(input cfg_t c);
		cfg_idx_t    r;
		logic [31:0] v;
		r = REG_CHARGE_GAIN;
		do begin
			case (r)
				REG_CHARGE_GAIN:     v = c.charge_gain;
				REG_DEADBAND_MA:     v = 32'(c.deadband_ma);
				REG_TAIL_CURRENT_MA: v = 32'(c.tail_current_ma);
				REG_FULL_VOLTAGE_MV: v = 32'(c.full_voltage_mv);
				REG_FULL_HOLD_MS:    v = c.full_hold_ms;
				REG_SOC_LOW_PCT:     v = 32'(c.soc_low_pct);
				REG_SOC_RECOVER_PCT: v = 32'(c.soc_recover_pct);
				default:             v = 32'(c.critical_mv);
			endcase
			cfg_we <= 1'b1;
			cfg_index <= r;
			cfg_data <= v;
			@(posedge clk);
			r = r.next();
		end while (r != REG_CHARGE_GAIN);
		cfg_we <= 1'b0;
	endtask

	function automatic cfg_t phase_settings(input int phase);
		cfg_t c;
		case (phase)
			0: c = '{32'hFFFF_FFFF, 15'd0, 15'd32767, 16'd0, 32'd0, 7'd0, 7'd0, 16'd0};
			1: c = '{32'd1, 15'd32767, 15'd0, 16'd65535, 32'hFFFF_FFFF, 7'd100, 7'd100,
				16'd65535};
			2: c = '{32'hC000_0000, 15'd200, 15'd1500, 16'd13000, 32'd5000, 7'd20, 7'd30,
				16'd11000};
			3: c = '{32'h8000_0000, 15'd1000, 15'd3000, 16'd12000, 32'd3000, 7'd40, 7'd35,
				16'd12000};
			4: begin
				c.charge_gain = $urandom_range(32'hFFFF_FFFF, 32'h4000_0000);
				c.deadband_ma = 15'($urandom_range(0, 2000));
				c.tail_current_ma = 15'($urandom_range(0, 4000));
				c.full_voltage_mv = 16'($urandom_range(11000, 15000));
				c.full_hold_ms = $urandom_range(0, 8000);
				c.soc_low_pct = 7'($urandom_range(0, 100));
				c.soc_recover_pct = 7'($urandom_range(0, 100));
				c.critical_mv = 16'($urandom_range(9000, 13000));
			end
			default: c = '{32'hFFFF_0000, 15'd50, 15'd2000, 16'd14400, 32'd4000, 7'd20,
				7'd30, 16'd11000};
		endcase
		return c;
	endfunction

	function automatic logic [15:0] volts_near(input int centre, input int spread);
		int v;
		v = centre + int'($urandom_range(0, 2 * spread)) - spread;
		if (v < 0)
			v = 0;
		if (v > 65535)
			v = 65535;
		return 16'(v);
	endfunction

	task automatic run_samples(input int count);
		load_mode_t  mode;
		int          left;
		int          done;
		int          mag;
		logic [31:0] gap;
		logic [15:0] mv;
		logic [15:0] amps;
		left = 0;
		done = 0;
		mode = NOISE;
		while (done < count) begin
			if (left == 0) begin
				mode = load_mode_t'($urandom_range(0, 3));
				left = $urandom_range(6, 20);
			end
			left--;
			case ($urandom_range(0, 19))
				0: gap = $urandom_range(0, SAMPLE_PERIOD_MS - 1);
				1: gap = $urandom;
				2: gap = $urandom_range(65536, 400000);
				default: gap = (mode == FLOAT) ? $urandom_range(1000, 4000)
					: $urandom_range(1000, 20000);
			endcase
			case (mode)
				DRAIN: begin
					amps = 16'($urandom_range(100, 32767));
					mv = volts_near(int'(shadow.critical_mv), 800);
				end
				CHARGE: begin
					amps = 16'(-int'($urandom_range(100, 32768)));
					mv = $urandom_range(0, 1) ? volts_near(int'(shadow.full_voltage_mv), 300)
						: volts_near(int'(shadow.critical_mv), 800);
				end
				FLOAT: begin
					mag = $urandom_range(0, int'(shadow.tail_current_ma));
					amps = $urandom_range(0, 1) ? 16'(-mag) : 16'(mag);
					mv = volts_near(int'(shadow.full_voltage_mv) + 100, 150);
				end
				default: begin
					amps = 16'($urandom);
					mv = 16'($urandom);
				end
			endcase
			clock_ms = clock_ms + gap;
			send_sample(clock_ms, $urandom_range(0, 15) != 0, mv, amps);
			if (gap >= SAMPLE_PERIOD_MS)
				done++;
		end
	endtask

	initial begin
		shadow = phase_settings(5);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_sample(32'd0, 1'b1, 16'd12000, 16'd0);
		send_sample(32'd999, 1'b1, 16'd12000, 16'd0);
		send_sample(32'd1000, 1'b1, 16'd0, 16'd0);
		send_sample(32'd2000, 1'b0, 16'hFFFF, 16'h8000);
		send_sample(32'd3000, 1'b1, 16'hFFFF, 16'h8000);
		send_sample(32'd4000, 1'b1, 16'd11000, 16'd50);
		send_sample(32'd5000, 1'b1, 16'd11499, 16'd51);
		send_sample(32'd6000, 1'b1, 16'd11500, -16'sd51);
		send_sample(32'd106000, 1'b1, 16'd12000, 16'h7FFF);
		send_sample(32'd107000, 1'b1, 16'd14400, 16'd2000);
		send_sample(32'd137000, 1'b1, 16'd15000, 16'd0);
		send_sample(32'd167000, 1'b1, 16'd14400, -16'sd2000);
		send_sample(32'd168000, 1'b1, 16'd14401, 16'd2001);
		send_sample(32'hFFFF_FC00, 1'b1, 16'd14400, 16'd0);
		send_sample(32'h0000_0100, 1'b1, 16'd14400, 16'd0);
		send_sample(32'h0000_0200, 1'b1, 16'd14400, 16'd0);
		send_sample(32'h0000_0500, 1'b0, 16'h5A5A, 16'hA5A5);
		clock_ms = 32'h0000_0500;
		for (int phase = 0; phase < 6; phase++) begin
			settle();
			shadow = phase_settings(phase);
			load_settings(shadow);
			if (phase == 5)
				calm = 1'b1;
			run_samples(65);
		end
		settle();
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
